>>> src/sbdc_pkg.sv
// Shared types, widths and constants of the balancing drive controller.
`default_nettype none

package sbdc_pkg;

  // Parameter defaults
  localparam int unsigned LATCH_TICKS_DEF   = 18;
  localparam int unsigned FRACTION_BITS_DEF = 8;

  // Gains carry 16 fraction bits
  localparam int unsigned GAIN_BITS = 16;

  // Field and state widths
  localparam int unsigned PITCH_W    = 17;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned PULSE_W    = 8;
  localparam int unsigned DUTY_W     = 13;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned TILT_W     = 16;
  localparam int unsigned INT_LIM_W  = 20;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned SPEED_W    = 28;
  localparam int unsigned POS_W      = 30;

  // Control constants
  localparam int TURN_MAG  = 700;
  localparam int MOVE_SLOW = 45;
  localparam int MOVE_FAST = 60;

  // Register reset values
  localparam logic [GAIN_W-1:0]    BAL_P_RST    = 24'd9830400;
  localparam logic [GAIN_W-1:0]    BAL_D_RST    = 24'd62259;
  localparam logic [GAIN_W-1:0]    SPEED_P_RST  = 24'd1310720;
  localparam logic [GAIN_W-1:0]    SPEED_I_RST  = 24'd721;
  localparam logic [DUTY_W-1:0]    DEADZONE_RST = 13'd4000;
  localparam logic [DUTY_W-1:0]    DUTY_LIM_RST = 13'd6900;
  localparam logic [TILT_W-1:0]    TILT_RST     = 16'd6400;
  localparam logic [INT_LIM_W-1:0] INT_LIM_RST  = 20'd100000;

  // Configuration register index
  typedef enum logic [2:0] {
    REG_BAL_P,
    REG_BAL_D,
    REG_SPEED_P,
    REG_SPEED_I,
    REG_DEADZONE,
    REG_DUTY_LIMIT,
    REG_TILT_LIMIT,
    REG_INT_LIMIT
  } cfg_idx_t;

  // H-bridge drive code
  typedef enum logic [1:0] {
    DRV_OFF = 2'd0,
    DRV_FWD = 2'd1,
    DRV_REV = 2'd2
  } drive_code_t;

endpackage

`default_nettype wire

>>> src/sbdc_if.sv
// Channel interfaces: control tick in, drive result out, register write.
`default_nettype none

interface sbdc_tick_if;
  import sbdc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [PITCH_W-1:0] pitch;
  logic signed [RATE_W-1:0]  pitch_rate;
  logic signed [PULSE_W-1:0] pulses_left;
  logic signed [PULSE_W-1:0] pulses_right;
  logic                      go_forward;
  logic                      go_backward;
  logic                      turn_left;
  logic                      turn_right;
  logic                      fast_mode;

  modport source (
    output valid, pitch, pitch_rate, pulses_left, pulses_right,
           go_forward, go_backward, turn_left, turn_right, fast_mode,
    input  ready
  );
  modport sink (
    input  valid, pitch, pitch_rate, pulses_left, pulses_right,
           go_forward, go_backward, turn_left, turn_right, fast_mode,
    output ready
  );
endinterface

interface sbdc_drive_if;
  import sbdc_pkg::*;
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty_left;
  drive_code_t       drive_left;
  logic [DUTY_W-1:0] duty_right;
  drive_code_t       drive_right;
  logic              tilted_stop;

  modport source (
    output valid, duty_left, drive_left, duty_right, drive_right, tilted_stop,
    input  ready
  );
  modport sink (
    input  valid, duty_left, drive_left, duty_right, drive_right, tilted_stop,
    output ready
  );
endinterface

interface sbdc_cfg_if;
  import sbdc_pkg::*;
  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/self_balancing_drive_controller.sv
// Balance PD + speed PI drive controller around one shared multiplier.
// A new tick is accepted only while the sequencer is idle, after the last one has
// left the mix step; the one multiplier takes six products over eight sequencer
// steps, followed by the mix/saturate step.
// The output register holds a finished item while the next tick is accepted;
// the mix step waits while that item has not been taken.
// Reset (rst, synchronous): sequencer idle, output empty, registers to their
// defaults, counters, sums, filter, position and held duties cleared.
`default_nettype none

module self_balancing_drive_controller #(
  parameter int unsigned LATCH_TICKS   = sbdc_pkg::LATCH_TICKS_DEF,
  parameter int unsigned FRACTION_BITS = sbdc_pkg::FRACTION_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  sbdc_tick_if.sink    tick,
  sbdc_drive_if.source drive,
  sbdc_cfg_if.sink     cfg
);
  import sbdc_pkg::*;

  localparam int unsigned MUL_A_W   = 31;
  localparam int unsigned MUL_B_W   = GAIN_W + 1;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W     = 40;
  localparam int unsigned MIX_W     = ACC_W + 2;
  localparam int unsigned POS_SUM_W = 36;
  localparam int unsigned WHEEL_W   = SUM_W + 1;

  // Filter weights, a + b is exactly one
  localparam int FILT_A = (4 * (2 ** FRACTION_BITS) + 2) / 5;
  localparam int FILT_B = (2 ** FRACTION_BITS) - FILT_A;
  localparam logic signed [MUL_B_W-1:0] FILT_A_OP = MUL_B_W'(FILT_A);
  localparam logic signed [MUL_B_W-1:0] FILT_B_OP = MUL_B_W'(FILT_B);

  localparam logic signed [ACC_W-1:0] SPEED_HI = ACC_W'(2 ** (SPEED_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] SPEED_LO = ACC_W'(-(2 ** (SPEED_W - 1)));
  localparam logic signed [POS_SUM_W-1:0] POS_HI = POS_SUM_W'(2 ** (POS_W - 1) - 1);
  localparam logic signed [POS_SUM_W-1:0] POS_LO = POS_SUM_W'(-(2 ** (POS_W - 1)));
  localparam logic signed [MIX_W-1:0] TURN_POS = MIX_W'(TURN_MAG);

  // Truncation masks for the three shifted product scalings
  localparam logic signed [PROD_W-1:0] MASK_GF =
    (PROD_W'(1) << (FRACTION_BITS + GAIN_BITS)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] MASK_G = (PROD_W'(1) << GAIN_BITS) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] MASK_F = (PROD_W'(1) << FRACTION_BITS) - PROD_W'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BAL_P,
    S_BAL_D,
    S_FILT_A,
    S_FILT_B,
    S_FILT_SUM,
    S_POS,
    S_VEL_P,
    S_VEL_I,
    S_MIX
  } state_t;

  typedef enum logic [1:0] {
    SH_GAIN_F,
    SH_GAIN,
    SH_FRAC,
    SH_NONE
  } shift_t;

  // Configuration registers
  logic [GAIN_W-1:0]    balance_gain_p;
  logic [GAIN_W-1:0]    balance_gain_d;
  logic [GAIN_W-1:0]    speed_gain_p;
  logic [GAIN_W-1:0]    speed_gain_i;
  logic [DUTY_W-1:0]    deadzone_offset;
  logic [DUTY_W-1:0]    duty_limit;
  logic [TILT_W-1:0]    tilt_limit;
  logic [INT_LIM_W-1:0] integral_limit;

  // Controller state
  state_t                    state;
  logic [COUNT_W-1:0]        tick_count;
  logic signed [SUM_W-1:0]   pulse_sum_left;
  logic signed [SUM_W-1:0]   pulse_sum_right;
  logic signed [SUM_W-1:0]   latched_speed_left;
  logic signed [SUM_W-1:0]   latched_speed_right;
  logic signed [SPEED_W-1:0] filtered_speed;
  logic signed [POS_W-1:0]   position_integral;
  logic [DUTY_W-1:0]         held_left;
  logic [DUTY_W-1:0]         held_right;

  // Latched tick fields
  logic signed [PITCH_W-1:0] pitch_r;
  logic signed [RATE_W-1:0]  rate_r;
  logic                      fwd_r;
  logic                      back_r;
  logic                      tl_r;
  logic                      tr_r;
  logic                      fast_r;

  // Datapath registers
  logic signed [PROD_W-1:0] prod;
  shift_t                   prod_sh;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  filt_part;

  // Output registers
  logic        out_valid;
  drive_code_t drive_left_q;
  drive_code_t drive_right_q;
  logic        tilted_q;

  // Combinational signals
  logic signed [SUM_W-1:0]     sum_l_inc;
  logic signed [SUM_W-1:0]     sum_r_inc;
  logic [COUNT_W-1:0]          count_inc;
  logic signed [WHEEL_W-1:0]   wheel_sum;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  shift_t                      sh_next;
  logic signed [PROD_W-1:0]    bias;
  logic signed [PROD_W-1:0]    prod_biased;
  logic signed [PROD_W-1:0]    prod_shifted;
  logic signed [ACC_W-1:0]     term;
  logic signed [ACC_W-1:0]     filt_sum;
  logic signed [ACC_W-1:0]     filt_sat;
  logic signed [POS_SUM_W-1:0] move_raw;
  logic signed [POS_SUM_W-1:0] move_q;
  logic signed [POS_SUM_W-1:0] pos_lim;
  logic signed [POS_SUM_W-1:0] pos_sum;
  logic signed [POS_SUM_W-1:0] pos_clamp;
  logic signed [POS_SUM_W-1:0] pos_sat;
  logic signed [PITCH_W:0]     pitch_ext;
  logic [PITCH_W:0]            pitch_abs;
  logic                        tilted;
  logic signed [MIX_W-1:0]     turn_val;
  logic signed [MIX_W-1:0]     m1_raw;
  logic signed [MIX_W-1:0]     m2_raw;
  logic signed [MIX_W-1:0]     dz_s;
  logic signed [MIX_W-1:0]     dl_s;
  logic signed [MIX_W-1:0]     m1_dz;
  logic signed [MIX_W-1:0]     m2_dz;
  logic signed [MIX_W-1:0]     m1_sat;
  logic signed [MIX_W-1:0]     m2_sat;
  logic signed [MIX_W-1:0]     m1_abs;
  logic signed [MIX_W-1:0]     m2_abs;
  logic                        out_free;

  assign tick.ready        = (state == S_IDLE);
  assign cfg.ready         = 1'b1;
  assign drive.valid       = out_valid;
  assign drive.duty_left   = held_left;
  assign drive.duty_right  = held_right;
  assign drive.drive_left  = drive_left_q;
  assign drive.drive_right = drive_right_q;
  assign drive.tilted_stop = tilted_q;
  assign out_free          = !out_valid || drive.ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      balance_gain_p  <= BAL_P_RST;
      balance_gain_d  <= BAL_D_RST;
      speed_gain_p    <= SPEED_P_RST;
      speed_gain_i    <= SPEED_I_RST;
      deadzone_offset <= DEADZONE_RST;
      duty_limit      <= DUTY_LIM_RST;
      tilt_limit      <= TILT_RST;
      integral_limit  <= INT_LIM_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_BAL_P:      balance_gain_p  <= cfg.data[GAIN_W-1:0];
        REG_BAL_D:      balance_gain_d  <= cfg.data[GAIN_W-1:0];
        REG_SPEED_P:    speed_gain_p    <= cfg.data[GAIN_W-1:0];
        REG_SPEED_I:    speed_gain_i    <= cfg.data[GAIN_W-1:0];
        REG_DEADZONE:   deadzone_offset <= cfg.data[DUTY_W-1:0];
        REG_DUTY_LIMIT: duty_limit      <= cfg.data[DUTY_W-1:0];
        REG_TILT_LIMIT: tilt_limit      <= cfg.data[TILT_W-1:0];
        REG_INT_LIMIT:  integral_limit  <= cfg.data[INT_LIM_W-1:0];
      endcase
    end
  end

  // Encoder accumulation for the incoming tick
  assign sum_l_inc = pulse_sum_left + SUM_W'(tick.pulses_left);
  assign sum_r_inc = pulse_sum_right + SUM_W'(tick.pulses_right);
  assign count_inc = tick_count + COUNT_W'(1);
  assign wheel_sum = WHEEL_W'(latched_speed_left) + WHEEL_W'(latched_speed_right);

  // Operand select for the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    sh_next = SH_NONE;
    case (state)
      S_BAL_P: begin
        mul_a   = MUL_A_W'(pitch_r);
        mul_b   = {1'b0, balance_gain_p};
        sh_next = SH_GAIN_F;
      end
      S_BAL_D: begin
        mul_a   = MUL_A_W'(rate_r);
        mul_b   = {1'b0, balance_gain_d};
        sh_next = SH_GAIN;
      end
      S_FILT_A: begin
        mul_a   = MUL_A_W'(filtered_speed);
        mul_b   = FILT_A_OP;
        sh_next = SH_FRAC;
      end
      S_FILT_B: begin
        mul_a   = MUL_A_W'(wheel_sum);
        mul_b   = FILT_B_OP;
        sh_next = SH_NONE;
      end
      S_POS: begin
        mul_a   = MUL_A_W'(filtered_speed);
        mul_b   = {1'b0, speed_gain_p};
        sh_next = SH_GAIN_F;
      end
      S_VEL_P: begin
        mul_a   = MUL_A_W'(position_integral);
        mul_b   = {1'b0, speed_gain_i};
        sh_next = SH_GAIN_F;
      end
      default: begin
        mul_a   = '0;
      end
    endcase
  end

  // Scale the registered product down, truncating toward zero
  always_comb begin
    case (prod_sh)
      SH_GAIN_F: bias = MASK_GF;
      SH_GAIN:   bias = MASK_G;
      SH_FRAC:   bias = MASK_F;
      default:   bias = '0;
    endcase
    prod_biased = prod + (prod[PROD_W-1] ? bias : PROD_W'(0));
    case (prod_sh)
      SH_GAIN_F: prod_shifted = prod_biased >>> (FRACTION_BITS + GAIN_BITS);
      SH_GAIN:   prod_shifted = prod_biased >>> GAIN_BITS;
      SH_FRAC:   prod_shifted = prod_biased >>> FRACTION_BITS;
      default:   prod_shifted = prod_biased;
    endcase
    term = prod_shifted[ACC_W-1:0];
  end

  // Low-pass filter sum, saturated to the speed range
  always_comb begin
    filt_sum = filt_part + term;
    if (filt_sum > SPEED_HI) begin
      filt_sat = SPEED_HI;
    end else if (filt_sum < SPEED_LO) begin
      filt_sat = SPEED_LO;
    end else begin
      filt_sat = filt_sum;
    end
  end

  // Position update: speed minus commanded motion, clamped twice
  always_comb begin
    move_raw = fast_r ? POS_SUM_W'(MOVE_FAST) : POS_SUM_W'(MOVE_SLOW);
    if (fwd_r) begin
      move_q = move_raw <<< FRACTION_BITS;
    end else if (back_r) begin
      move_q = -(move_raw <<< FRACTION_BITS);
    end else begin
      move_q = '0;
    end
    pos_lim = POS_SUM_W'(integral_limit) << FRACTION_BITS;
    pos_sum = POS_SUM_W'(position_integral) + POS_SUM_W'(filtered_speed) - move_q;
    if (pos_sum > pos_lim) begin
      pos_clamp = pos_lim;
    end else if (pos_sum < -pos_lim) begin
      pos_clamp = -pos_lim;
    end else begin
      pos_clamp = pos_sum;
    end
    if (pos_clamp > POS_HI) begin
      pos_sat = POS_HI;
    end else if (pos_clamp < POS_LO) begin
      pos_sat = POS_LO;
    end else begin
      pos_sat = pos_clamp;
    end
  end

  // Tilt detect
  assign pitch_ext = (PITCH_W + 1)'(pitch_r);
  assign pitch_abs = pitch_ext[PITCH_W] ? -pitch_ext : pitch_ext;
  assign tilted    = pitch_abs > (PITCH_W + 1)'(tilt_limit);

  // Turn, dead zone and drive saturation
  always_comb begin
    if (tl_r) begin
      turn_val = TURN_POS;
    end else if (tr_r) begin
      turn_val = -TURN_POS;
    end else begin
      turn_val = '0;
    end
    m1_raw = MIX_W'(acc) + turn_val;
    m2_raw = MIX_W'(acc) - turn_val;
    dz_s   = MIX_W'(deadzone_offset);
    dl_s   = MIX_W'(duty_limit);
    if (m1_raw[MIX_W-1] || m2_raw[MIX_W-1]) begin
      m1_dz = m1_raw - dz_s;
      m2_dz = m2_raw - dz_s;
    end else begin
      m1_dz = m1_raw + dz_s;
      m2_dz = m2_raw + dz_s;
    end
    if (m1_dz > dl_s) begin
      m1_sat = dl_s;
    end else if (m1_dz < -dl_s) begin
      m1_sat = -dl_s;
    end else begin
      m1_sat = m1_dz;
    end
    if (m2_dz > dl_s) begin
      m2_sat = dl_s;
    end else if (m2_dz < -dl_s) begin
      m2_sat = -dl_s;
    end else begin
      m2_sat = m2_dz;
    end
    m1_abs = m1_sat[MIX_W-1] ? -m1_sat : m1_sat;
    m2_abs = m2_sat[MIX_W-1] ? -m2_sat : m2_sat;
  end

  // Payload registers of the multiplier stage
  always_ff @(posedge clk) begin
    prod    <= PROD_W'(mul_a) * PROD_W'(mul_b);
    prod_sh <= sh_next;
  end

  // Sequencer, controller state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      tick_count          <= '0;
      pulse_sum_left      <= '0;
      pulse_sum_right     <= '0;
      latched_speed_left  <= '0;
      latched_speed_right <= '0;
      filtered_speed      <= '0;
      position_integral   <= '0;
      held_left           <= '0;
      held_right          <= '0;
      out_valid           <= 1'b0;
      drive_left_q        <= DRV_OFF;
      drive_right_q       <= DRV_OFF;
      tilted_q            <= 1'b0;
    end else begin
      // the mix step refills the output itself when it is taken
      if (out_valid && drive.ready && state != S_MIX) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (tick.valid) begin
            pitch_r <= tick.pitch;
            rate_r  <= tick.pitch_rate;
            fwd_r   <= tick.go_forward;
            back_r  <= tick.go_backward;
            tl_r    <= tick.turn_left;
            tr_r    <= tick.turn_right;
            fast_r  <= tick.fast_mode;
            // latch wheel speeds once per window, left negated
            if (count_inc == COUNT_W'(LATCH_TICKS)) begin
              latched_speed_left  <= -sum_l_inc;
              latched_speed_right <= sum_r_inc;
              pulse_sum_left      <= '0;
              pulse_sum_right     <= '0;
              tick_count          <= '0;
            end else begin
              pulse_sum_left  <= sum_l_inc;
              pulse_sum_right <= sum_r_inc;
              tick_count      <= count_inc;
            end
            state <= S_BAL_P;
          end
        end
        S_BAL_P: begin
          state <= S_BAL_D;
        end
        S_BAL_D: begin
          acc   <= term;
          state <= S_FILT_A;
        end
        S_FILT_A: begin
          acc   <= acc + term;
          state <= S_FILT_B;
        end
        S_FILT_B: begin
          filt_part <= term;
          state     <= S_FILT_SUM;
        end
        S_FILT_SUM: begin
          filtered_speed <= filt_sat[SPEED_W-1:0];
          state          <= S_POS;
        end
        S_POS: begin
          position_integral <= pos_sat[POS_W-1:0];
          state             <= S_VEL_P;
        end
        S_VEL_P: begin
          acc   <= acc + term;
          state <= S_VEL_I;
        end
        S_VEL_I: begin
          acc <= acc + term;
          // speed term has used the position; clear it when tipped over
          if (tilted) begin
            position_integral <= '0;
          end
          state <= S_MIX;
        end
        S_MIX: begin
          if (out_free) begin
            if (!tilted) begin
              held_left  <= m1_abs[DUTY_W-1:0];
              held_right <= m2_abs[DUTY_W-1:0];
            end
            drive_left_q  <= tilted ? DRV_OFF : (m1_sat[MIX_W-1] ? DRV_REV : DRV_FWD);
            drive_right_q <= tilted ? DRV_OFF : (m2_sat[MIX_W-1] ? DRV_REV : DRV_FWD);
            tilted_q      <= tilted;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    tick.valid && tick.ready |=> !tick.ready)
    else $error("tick accepted while sequencer busy");

  a_tilt_bridges_off: assert property (@(posedge clk) disable iff (rst)
    drive.valid && drive.tilted_stop |->
      drive.drive_left == DRV_OFF && drive.drive_right == DRV_OFF)
    else $error("bridges driven during tilt stop");

  a_upright_bridges_on: assert property (@(posedge clk) disable iff (rst)
    drive.valid && !drive.tilted_stop |->
      drive.drive_left != DRV_OFF && drive.drive_right != DRV_OFF)
    else $error("bridge off while upright");

  a_count_window: assert property (@(posedge clk) disable iff (rst)
    32'(tick_count) < LATCH_TICKS)
    else $error("tick counter passed latch window");

  a_result_from_mix: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_MIX))
    else $error("result raised outside mix step");

endmodule

`default_nettype wire

>>> dv/self_balancing_drive_controller_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the balancing drive controller: ticks in, drive items checked.

module self_balancing_drive_controller_test;
  import sbdc_pkg::*;

  localparam int unsigned LATCH = LATCH_TICKS_DEF;
  localparam int unsigned FB    = FRACTION_BITS_DEF;

  // Timing budget
  localparam int     LATENCY     = 10;
  localparam int     HOLD_CYCLES = 300;
  localparam longint LIMIT_NS    = 1_000_000;

  // Field extremes
  localparam int PITCH_MAX = 46080;
  localparam int RATE_MAX  = 32767;
  localparam int RATE_MIN  = -32768;
  localparam int PULSE_MAX = 127;
  localparam int PULSE_MIN = -128;

  // Register extremes
  localparam longint GAIN_MAX    = (longint'(1) << GAIN_W) - 1;
  localparam longint DUTY_MAX    = (longint'(1) << DUTY_W) - 1;
  localparam longint INT_LIM_MAX = (longint'(1) << INT_LIM_W) - 1;

  // Fixed-point constants of the speed filter and the state bounds
  localparam longint FILT_A    = (4 * (longint'(1) << FB) + 2) / 5;
  localparam longint FILT_B    = (longint'(1) << FB) - FILT_A;
  localparam longint SPEED_MAX = (longint'(1) << (SPEED_W - 1)) - 1;
  localparam longint POS_MAX   = (longint'(1) << (POS_W - 1)) - 1;

  // Remote command bits
  localparam bit [4:0] CMD_NONE  = 5'b00000;
  localparam bit [4:0] CMD_FWD   = 5'b00001;
  localparam bit [4:0] CMD_BACK  = 5'b00010;
  localparam bit [4:0] CMD_LEFT  = 5'b00100;
  localparam bit [4:0] CMD_RIGHT = 5'b01000;
  localparam bit [4:0] CMD_FAST  = 5'b10000;

  typedef struct {
    logic signed [PITCH_W-1:0] pitch;
    logic signed [RATE_W-1:0]  pitch_rate;
    logic signed [PULSE_W-1:0] pulses_left;
    logic signed [PULSE_W-1:0] pulses_right;
    logic                      go_forward;
    logic                      go_backward;
    logic                      turn_left;
    logic                      turn_right;
    logic                      fast_mode;
  } tick_t;

  typedef struct {
    logic [DUTY_W-1:0] duty_left;
    drive_code_t       drive_left;
    logic [DUTY_W-1:0] duty_right;
    drive_code_t       drive_right;
    logic              tilted_stop;
  } drive_t;

  logic clk;
  logic rst;

  sbdc_tick_if  tick ();
  sbdc_drive_if drive ();
  sbdc_cfg_if   cfg ();

  self_balancing_drive_controller #(
    .LATCH_TICKS   (LATCH),
    .FRACTION_BITS (FB)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick),
    .drive (drive),
    .cfg   (cfg)
  );

  // Controller state mirrored by the predictor
  longint                  cfg_val [8];
  logic [COUNT_W-1:0]      tick_cnt;
  logic signed [SUM_W-1:0] sum_l, sum_r, speed_l, speed_r;
  longint                  filt_speed, position;
  logic [DUTY_W-1:0]       held_l, held_r;
  drive_t                  pending_drive [$];

  // Run statistics
  int ticks_sent     = 0;
  int drives_seen    = 0;
  int tilted_seen    = 0;
  int settings_run   = 0;
  int mismatch_count = 0;

  // Stimulus knobs
  bit tx_steady    = 1'b0;
  bit rx_steady    = 1'b0;
  bit pulse_steady = 1'b0;
  bit hold_req     = 1'b0;
  int bias_l       = 0;
  int bias_r       = 0;

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic longint trunc_shift(longint x, int s);
    return (x < 0) ? -((-x) >>> s) : (x >>> s);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Advance the controller by one tick and return the drive item it yields
  function automatic drive_t compute_drive(tick_t t);
    longint unit_v, pitch_v, bal, vel, turn, mv, lim, m1, m2, dz;
    bit     tilted;
    drive_t r;
    unit_v = longint'(1) << FB;

    // Pulse sums and periodic speed latch (left wheel negated)
    sum_l    = sum_l + SUM_W'(t.pulses_left);
    sum_r    = sum_r + SUM_W'(t.pulses_right);
    tick_cnt = tick_cnt + COUNT_W'(1);
    if (tick_cnt == LATCH) begin
      speed_l  = -sum_l;
      speed_r  = sum_r;
      sum_l    = '0;
      sum_r    = '0;
      tick_cnt = '0;
    end

    pitch_v = t.pitch;
    tilted  = ((pitch_v < 0) ? -pitch_v : pitch_v) > cfg_val[REG_TILT_LIMIT];

    // Balance PD term
    bal = trunc_shift(pitch_v * cfg_val[REG_BAL_P], FB + GAIN_BITS)
        + trunc_shift(longint'(t.pitch_rate) * cfg_val[REG_BAL_D], GAIN_BITS);

    // Speed PI term: filter, integrate against the commanded motion, clamp
    mv = t.fast_mode ? MOVE_FAST : MOVE_SLOW;
    mv = t.go_forward ? mv : (t.go_backward ? -mv : 0);
    filt_speed = clip(trunc_shift(filt_speed * FILT_A, FB)
                      + (longint'(speed_l) + longint'(speed_r)) * FILT_B,
                      -SPEED_MAX - 1, SPEED_MAX);
    lim      = cfg_val[REG_INT_LIMIT] * unit_v;
    position = clip(position + filt_speed - mv * unit_v, -lim, lim);
    position = clip(position, -POS_MAX - 1, POS_MAX);
    vel = trunc_shift(filt_speed * cfg_val[REG_SPEED_P], FB + GAIN_BITS)
        + trunc_shift(position * cfg_val[REG_SPEED_I], FB + GAIN_BITS);
    if (tilted) position = 0;

    // Turn, dead zone (common sign for both wheels), saturation
    turn = t.turn_left ? TURN_MAG : (t.turn_right ? -TURN_MAG : 0);
    m1   = bal + vel + turn;
    m2   = bal + vel - turn;
    dz   = (m1 < 0 || m2 < 0) ? -cfg_val[REG_DEADZONE] : cfg_val[REG_DEADZONE];
    m1   = clip(m1 + dz, -cfg_val[REG_DUTY_LIMIT], cfg_val[REG_DUTY_LIMIT]);
    m2   = clip(m2 + dz, -cfg_val[REG_DUTY_LIMIT], cfg_val[REG_DUTY_LIMIT]);

    // Duties hold their last enabled value while tilted
    if (!tilted) begin
      held_l = DUTY_W'((m1 < 0) ? -m1 : m1);
      held_r = DUTY_W'((m2 < 0) ? -m2 : m2);
    end

    r.duty_left   = held_l;
    r.drive_left  = tilted ? DRV_OFF : ((m1 < 0) ? DRV_REV : DRV_FWD);
    r.duty_right  = held_r;
    r.drive_right = tilted ? DRV_OFF : ((m2 < 0) ? DRV_REV : DRV_FWD);
    r.tilted_stop = tilted;
    return r;
  endfunction

  function automatic tick_t make_tick(int p, int rate, int pl, int pr, bit [4:0] cmd);
    tick_t t;
    t.pitch        = PITCH_W'(p);
    t.pitch_rate   = RATE_W'(rate);
    t.pulses_left  = PULSE_W'(pl);
    t.pulses_right = PULSE_W'(pr);
    t.go_forward   = (cmd & CMD_FWD) != 0;
    t.go_backward  = (cmd & CMD_BACK) != 0;
    t.turn_left    = (cmd & CMD_LEFT) != 0;
    t.turn_right   = (cmd & CMD_RIGHT) != 0;
    t.fast_mode    = (cmd & CMD_FAST) != 0;
    return t;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Pitch mostly inside the tilt window, with full range and edge values too
  function automatic tick_t random_tick();
    int       span, p, r, rate, pl, pr;
    bit [4:0] cmd;
    span = (cfg_val[REG_TILT_LIMIT] < PITCH_MAX) ? int'(cfg_val[REG_TILT_LIMIT]) : PITCH_MAX;
    r = $urandom_range(0, 99);
    if (r < 70)      p = $urandom_range(0, span);
    else if (r < 90) p = $urandom_range(0, PITCH_MAX);
    else if (r < 94) p = PITCH_MAX;
    else if (r < 97) p = span;
    else             p = (span < PITCH_MAX) ? span + 1 : span;
    if ($urandom_range(0, 1) != 0) p = -p;
    if ($urandom_range(0, 4) == 0) rate = int'($urandom_range(0, 1000)) - 500;
    else                           rate = int'($urandom_range(0, 65535)) + RATE_MIN;
    if (pulse_steady) begin
      pl = bias_l + int'($urandom_range(0, 6)) - 3;
      pr = bias_r + int'($urandom_range(0, 6)) - 3;
    end else begin
      pl = int'($urandom_range(0, 255)) + PULSE_MIN;
      pr = int'($urandom_range(0, 255)) + PULSE_MIN;
    end
    cmd = 5'($urandom_range(0, 31));
    return make_tick(p, rate, pl, pr, cmd);
  endfunction

  // Offer one tick item; returns at the falling edge after it was taken
  task automatic send_tick(tick_t t);
    int n;
    n = tx_steady ? 0 : idle_len();
    if (n > 0) begin
      tick.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    tick.pitch        <= t.pitch;
    tick.pitch_rate   <= t.pitch_rate;
    tick.pulses_left  <= t.pulses_left;
    tick.pulses_right <= t.pulses_right;
    tick.go_forward   <= t.go_forward;
    tick.go_backward  <= t.go_backward;
    tick.turn_left    <= t.turn_left;
    tick.turn_right   <= t.turn_right;
    tick.fast_mode    <= t.fast_mode;
    tick.valid        <= 1'b1;
    do @(posedge clk); while (!tick.ready);
    pending_drive.push_back(compute_drive(t));
    ticks_sent++;
    @(negedge clk);
  endtask

  // Stop offering and let every outstanding drive item come back
  task automatic settle();
    tick.valid <= 1'b0;
    while (pending_drive.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, longint value);
    cfg.index <= idx;
    cfg.data  <= value[CFG_DATA_W-1:0];
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    cfg_val[idx] = value;
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(longint bal_p, longint bal_d, longint spd_p, longint spd_i,
                               longint dz, longint duty, longint tilt, longint ilim);
    settle();
    write_reg(REG_BAL_P, bal_p);
    write_reg(REG_BAL_D, bal_d);
    write_reg(REG_SPEED_P, spd_p);
    write_reg(REG_SPEED_I, spd_i);
    write_reg(REG_DEADZONE, dz);
    write_reg(REG_DUTY_LIMIT, duty);
    write_reg(REG_TILT_LIMIT, tilt);
    write_reg(REG_INT_LIMIT, ilim);
    settings_run++;
  endtask

  // Random ticks in segments, each with its own pulse drift and idling mix
  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        pulse_steady = 1'($urandom_range(0, 1));
        bias_l       = int'($urandom_range(0, 240)) - 120;
        bias_r       = int'($urandom_range(0, 240)) - 120;
        tx_steady    = ($urandom_range(0, 3) == 0);
        rx_steady    = ($urandom_range(0, 3) == 0);
      end
      send_tick(random_tick());
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic report_mismatch(string what, longint want, longint got);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t drive item %0d: %s expected %0d got %0d", $time, drives_seen, what, want,
               got);
  endtask

  // Field extremes, tilt boundary, a range of command combinations, first latch
  task automatic test_directed();
    int tl;
    tl = int'(TILT_RST);
    send_tick(make_tick(0, 0, 0, 0, CMD_NONE));
    send_tick(make_tick(PITCH_MAX, RATE_MAX, PULSE_MAX, PULSE_MAX, CMD_NONE));
    send_tick(make_tick(-PITCH_MAX, RATE_MIN, PULSE_MIN, PULSE_MIN, CMD_NONE));
    send_tick(make_tick(tl, 0, PULSE_MIN, PULSE_MAX, CMD_NONE));
    send_tick(make_tick(tl + 1, 0, PULSE_MIN, PULSE_MAX, CMD_NONE));
    send_tick(make_tick(-tl, 0, PULSE_MIN, PULSE_MAX, CMD_NONE));
    send_tick(make_tick(-tl - 1, 0, PULSE_MIN, PULSE_MAX, CMD_NONE));
    send_tick(make_tick(0, RATE_MAX, PULSE_MIN, PULSE_MAX, CMD_NONE));
    send_tick(make_tick(0, RATE_MIN, PULSE_MIN, PULSE_MAX, CMD_NONE));
    send_tick(make_tick(100, 0, PULSE_MIN, PULSE_MAX, CMD_FWD));
    send_tick(make_tick(100, 0, PULSE_MIN, PULSE_MAX, CMD_BACK));
    send_tick(make_tick(100, 0, PULSE_MIN, PULSE_MAX, CMD_FWD | CMD_BACK));
    send_tick(make_tick(100, 0, PULSE_MIN, PULSE_MAX, CMD_LEFT));
    send_tick(make_tick(100, 0, PULSE_MIN, PULSE_MAX, CMD_RIGHT));
    send_tick(make_tick(100, 0, PULSE_MIN, PULSE_MAX, CMD_LEFT | CMD_RIGHT));
    send_tick(make_tick(100, 0, PULSE_MIN, PULSE_MAX, CMD_FAST | CMD_FWD));
    send_tick(make_tick(100, 0, PULSE_MIN, PULSE_MAX, CMD_FAST | CMD_BACK));
    // speed latch falls on this tick
    send_tick(make_tick(256, 0, PULSE_MIN, PULSE_MAX,
                        CMD_FWD | CMD_BACK | CMD_LEFT | CMD_RIGHT | CMD_FAST));
    // turn term splits the wheel signs around the dead zone
    send_tick(make_tick(-20, 100, 5, -5, CMD_LEFT));
    send_tick(make_tick(20, -100, -5, 5, CMD_RIGHT));
    // drive saturation both ways
    send_tick(make_tick(tl - 1, RATE_MAX, 0, 0, CMD_NONE));
    send_tick(make_tick(1 - tl, RATE_MIN, 0, 0, CMD_NONE));
  endtask

  task automatic test_default_random();
    run_random(300);
  endtask

  // Register settings: all low, all high, tight clamps, random, then defaults
  task automatic test_register_sweep();
    apply_setting(0, 0, 0, 0, 0, 0, 0, 0);
    run_random(50);
    apply_setting(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, DUTY_MAX, DUTY_MAX, PITCH_MAX,
                  INT_LIM_MAX);
    run_random(60);
    apply_setting(BAL_P_RST, BAL_D_RST, SPEED_P_RST, GAIN_MAX, DEADZONE_RST, DUTY_LIM_RST,
                  PITCH_MAX, 150);
    run_random(50);
    apply_setting(BAL_P_RST, BAL_D_RST, SPEED_P_RST, SPEED_I_RST, DUTY_MAX, 100, TILT_RST,
                  INT_LIM_RST);
    run_random(40);
    repeat (4) begin
      apply_setting($urandom_range(0, GAIN_MAX), $urandom_range(0, GAIN_MAX),
                    $urandom_range(0, GAIN_MAX), $urandom_range(0, GAIN_MAX),
                    $urandom_range(0, DUTY_MAX), $urandom_range(0, DUTY_MAX),
                    $urandom_range(0, PITCH_MAX), $urandom_range(0, INT_LIM_MAX));
      run_random(40);
    end
    apply_setting(BAL_P_RST, BAL_D_RST, SPEED_P_RST, SPEED_I_RST, DEADZONE_RST, DUTY_LIM_RST,
                  TILT_RST, INT_LIM_RST);
    run_random(20);
  endtask

  // Receiver stalls for a long stretch while ticks keep coming back to back
  task automatic test_backpressure();
    hold_req  = 1'b1;
    tx_steady = 1'b1;
    repeat (40) send_tick(random_tick());
    tx_steady = 1'b0;
  endtask

  // Drive item receiver: random ready, with an occasional long hold-off
  initial begin
    int n;
    drive.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        drive.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        drive.ready <= 1'b1;
      end else begin
        n = rx_steady ? 0 : idle_len();
        if (n == 0) begin
          drive.ready <= 1'b1;
        end else begin
          drive.ready <= 1'b0;
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  // Drive item checker
  always @(posedge clk) begin
    drive_t want;
    if (!rst && drive.valid && drive.ready) begin
      drives_seen++;
      if (drive.tilted_stop) tilted_seen++;
      if (pending_drive.size() == 0) begin
        report_mismatch("item with none pending", 0, 0);
      end else begin
        want = pending_drive.pop_front();
        if (drive.duty_left !== want.duty_left)
          report_mismatch("duty_left", want.duty_left, drive.duty_left);
        if (drive.drive_left !== want.drive_left)
          report_mismatch("drive_left", want.drive_left, drive.drive_left);
        if (drive.duty_right !== want.duty_right)
          report_mismatch("duty_right", want.duty_right, drive.duty_right);
        if (drive.drive_right !== want.drive_right)
          report_mismatch("drive_right", want.drive_right, drive.drive_right);
        if (drive.tilted_stop !== want.tilted_stop)
          report_mismatch("tilted_stop", want.tilted_stop, drive.tilted_stop);
      end
    end
  end

  // Sequence
  initial begin
    rst                = 1'b1;
    tick.valid         = 1'b0;
    tick.pitch         = '0;
    tick.pitch_rate    = '0;
    tick.pulses_left   = '0;
    tick.pulses_right  = '0;
    tick.go_forward    = 1'b0;
    tick.go_backward   = 1'b0;
    tick.turn_left     = 1'b0;
    tick.turn_right    = 1'b0;
    tick.fast_mode     = 1'b0;
    cfg.valid          = 1'b0;
    cfg.index          = REG_BAL_P;
    cfg.data           = '0;

    // predictor reset state
    cfg_val[REG_BAL_P]      = BAL_P_RST;
    cfg_val[REG_BAL_D]      = BAL_D_RST;
    cfg_val[REG_SPEED_P]    = SPEED_P_RST;
    cfg_val[REG_SPEED_I]    = SPEED_I_RST;
    cfg_val[REG_DEADZONE]   = DEADZONE_RST;
    cfg_val[REG_DUTY_LIMIT] = DUTY_LIM_RST;
    cfg_val[REG_TILT_LIMIT] = TILT_RST;
    cfg_val[REG_INT_LIMIT]  = INT_LIM_RST;
    tick_cnt   = '0;
    sum_l      = '0;
    sum_r      = '0;
    speed_l    = '0;
    speed_r    = '0;
    filt_speed = 0;
    position   = 0;
    held_l     = '0;
    held_r     = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_default_random();
    test_register_sweep();
    test_backpressure();
    settle();

    $display("ran %0d control ticks across the reset setting and %0d written ones",
             ticks_sent, settings_run);
    $display("checked %0d drive items, %0d of them in tilt stop, %0d mismatches",
             drives_seen, tilted_seen, mismatch_count);
    if (mismatch_count == 0 && pending_drive.size() == 0) begin
      $display("self_balancing_drive_controller: match");
    end else begin
      $display("self_balancing_drive_controller: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("self_balancing_drive_controller: mismatch");
    $finish;
  end

endmodule
